[sv/easp_pkg.sv]
package easp_pkg;

    localparam int EXTENT_SLOTS = 256;
    localparam int SLOT_W       = $clog2(EXTENT_SLOTS);
    localparam int PAGE_W       = 36;
    localparam int LEN_W        = 20;

    typedef struct packed {
        logic [PAGE_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_ABSORB,
        ST_MERGE,
        ST_FILL,
        ST_RESP
    } state_t;

    // controls from the sequencer to the head of the ring
    typedef struct packed {
        state_t            mode;
        logic [PAGE_W-1:0] rel_start;
        logic [LEN_W-1:0]  count;
        logic [PAGE_W-1:0] rel_end;
        logic [PAGE_W-1:0] top;
        logic              found;
    } head_ctl_t;

    // status from the head back to the sequencer
    typedef struct packed {
        logic   hit;
        entry_t entry;
    } head_sts_t;

endpackage

[sv/easp_cell.sv]
module easp_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift_en,
    input  easp_pkg::entry_t d,
    output easp_pkg::entry_t q
);
    import easp_pkg::*;

    entry_t entry_reg;

    // one slot of the rotating extent ring
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else if (shift_en) begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

[sv/easp_head.sv]
module easp_head (
    input  easp_pkg::entry_t    entry_in,
    input  easp_pkg::head_ctl_t ctl,
    output easp_pkg::head_sts_t sts
);
    import easp_pkg::*;

    logic [PAGE_W-1:0] ent_end;
    logic [LEN_W:0]    len_sum;
    logic [LEN_W-1:0]  len_left;
    logic              nonempty;
    logic              fits;

    assign ent_end  = entry_in.start + PAGE_W'(entry_in.len);
    assign len_sum  = {1'b0, entry_in.len} + {1'b0, ctl.count};
    assign len_left = entry_in.len - ctl.count;
    assign nonempty = (entry_in.len != '0);
    assign fits     = !len_sum[LEN_W];

    // per-entry update for the active pass, first match only
    always_comb begin
        sts.hit   = 1'b0;
        sts.entry = entry_in;
        case (ctl.mode)
            ST_ALLOC: begin
                if (!ctl.found && entry_in.len >= ctl.count) begin
                    sts.hit       = 1'b1;
                    sts.entry.len = len_left;
                    sts.entry.start = (len_left == '0) ? '0
                                    : entry_in.start + PAGE_W'(ctl.count);
                end
            end
            ST_ABSORB: begin
                if (!ctl.found && nonempty && ent_end == ctl.top) begin
                    sts.hit   = 1'b1;
                    sts.entry = '0;
                end
            end
            ST_MERGE: begin
                if (!ctl.found && nonempty && fits) begin
                    if (ent_end == ctl.rel_start) begin
                        sts.hit       = 1'b1;
                        sts.entry.len = len_sum[LEN_W-1:0];
                    end else if (ctl.rel_end == entry_in.start) begin
                        sts.hit         = 1'b1;
                        sts.entry.start = ctl.rel_start;
                        sts.entry.len   = len_sum[LEN_W-1:0];
                    end
                end
            end
            ST_FILL: begin
                if (!ctl.found && !nonempty) begin
                    sts.hit         = 1'b1;
                    sts.entry.start = ctl.rel_start;
                    sts.entry.len   = ctl.count;
                end
            end
            default: begin
                sts.hit = 1'b0;
            end
        endcase
    end

endmodule

[sv/extent_table_space_allocator_unit.sv]
// channel  | direction | ports                                          | handshake
// request  | in        | s_kind, s_start_page, s_page_count             | s_valid / s_ready
// result   | out       | m_granted_page, m_from_table, m_release_dropped| m_valid / m_ready
// config   | in        | cfg_wdata                                      | cfg_wen
//
// The extent table is a ring of EXTENT_SLOTS cells that rotates one slot per cycle past a
// single update head, so one pass brings every slot past the head once.
// Allocate: one pass. Release: one pass to merge, a second to fill an empty slot if none merged;
// a release at the top takes one pass per absorbed extent plus one. An empty release makes no pass.
// Every word also goes through the idle accept state and the result state on top of its passes.
// Synchronous active-low reset clears all cells at once and sets the top to zero.
// One word at a time; a finished result waits in the output register for m_ready.
module extent_table_space_allocator_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [easp_pkg::PAGE_W-1:0]  cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [easp_pkg::PAGE_W-1:0]  s_start_page,
    input  logic [easp_pkg::LEN_W-1:0]   s_page_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [easp_pkg::PAGE_W-1:0]  m_granted_page,
    output logic                         m_from_table,
    output logic                         m_release_dropped
);
    import easp_pkg::*;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] cnt_reg, cnt_next;
    logic              found_reg, found_next;
    logic [PAGE_W-1:0] top_reg, top_next;
    logic [PAGE_W-1:0] rs_reg, rs_next;
    logic [LEN_W-1:0]  rn_reg, rn_next;
    logic [PAGE_W-1:0] res_page_reg, res_page_next;
    logic              res_tab_reg, res_tab_next;
    logic              res_drop_reg, res_drop_next;
    logic              m_valid_reg, m_valid_next;
    logic [PAGE_W-1:0] m_page_reg, m_page_next;
    logic              m_tab_reg, m_tab_next;
    logic              m_drop_reg, m_drop_next;

    entry_t    cell_q [EXTENT_SLOTS];
    entry_t    cell_d [EXTENT_SLOTS];
    logic      shift_en;
    head_ctl_t ctl;
    head_sts_t sts;
    logic      accept;
    logic      last;
    logic      hit_any;
    logic [PAGE_W-1:0] in_end;

    // ring of cells, head output feeds the tail
    genvar gi;
    generate
        for (gi = 0; gi < EXTENT_SLOTS; gi++) begin : g_cell
            if (gi == EXTENT_SLOTS - 1) begin : g_tail
                assign cell_d[gi] = sts.entry;
            end else begin : g_link
                assign cell_d[gi] = cell_q[gi+1];
            end
            easp_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d        (cell_d[gi]),
                .q        (cell_q[gi])
            );
        end
    endgenerate

    assign ctl.mode      = state_reg;
    assign ctl.rel_start = rs_reg;
    assign ctl.count     = rn_reg;
    assign ctl.rel_end   = rs_reg + PAGE_W'(rn_reg);
    assign ctl.top       = top_reg;
    assign ctl.found     = found_reg;

    easp_head u_head (
        .entry_in (cell_q[0]),
        .ctl      (ctl),
        .sts      (sts)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_end   = s_start_page + PAGE_W'(s_page_count);
    assign shift_en = (state_reg == ST_ALLOC) || (state_reg == ST_ABSORB)
                   || (state_reg == ST_MERGE) || (state_reg == ST_FILL);
    assign last     = (cnt_reg == SLOT_W'(EXTENT_SLOTS - 1));
    assign hit_any  = found_reg || sts.hit;

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            found_reg   <= 1'b0;
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            found_reg   <= found_next;
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rs_reg       <= rs_next;
        rn_reg       <= rn_next;
        res_page_reg <= res_page_next;
        res_tab_reg  <= res_tab_next;
        res_drop_reg <= res_drop_next;
        m_page_reg   <= m_page_next;
        m_tab_reg    <= m_tab_next;
        m_drop_reg   <= m_drop_next;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        top_next      = top_reg;
        rs_next       = rs_reg;
        rn_next       = rn_reg;
        res_page_next = res_page_reg;
        res_tab_next  = res_tab_reg;
        res_drop_next = res_drop_reg;
        m_valid_next  = m_valid_reg;
        m_page_next   = m_page_reg;
        m_tab_next    = m_tab_reg;
        m_drop_next   = m_drop_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (shift_en) begin
            cnt_next   = cnt_reg + SLOT_W'(1);
            found_next = hit_any;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cfg_wen) begin
                    top_next = cfg_wdata;
                end
                if (accept) begin
                    rs_next       = s_start_page;
                    rn_next       = s_page_count;
                    res_page_next = '0;
                    res_tab_next  = 1'b0;
                    res_drop_next = 1'b0;
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    if (!s_kind) begin
                        state_next = ST_ALLOC;
                    end else if (s_start_page == '0 || s_page_count == '0) begin
                        state_next = ST_RESP;
                    end else if (in_end == top_reg) begin
                        top_next   = s_start_page;
                        state_next = ST_ABSORB;
                    end else begin
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_ALLOC: begin
                if (sts.hit) begin
                    res_page_next = cell_q[0].start;
                    res_tab_next  = 1'b1;
                end
                if (last) begin
                    if (!hit_any) begin
                        res_page_next = top_reg;
                        top_next      = top_reg + PAGE_W'(rn_reg);
                    end
                    found_next = 1'b0;
                    state_next = ST_RESP;
                end
            end
            ST_ABSORB: begin
                if (sts.hit) begin
                    top_next = cell_q[0].start;
                end
                if (last) begin
                    found_next = 1'b0;
                    state_next = hit_any ? ST_ABSORB : ST_RESP;
                end
            end
            ST_MERGE: begin
                if (last) begin
                    found_next = 1'b0;
                    state_next = hit_any ? ST_RESP : ST_FILL;
                end
            end
            ST_FILL: begin
                if (last) begin
                    res_drop_next = !hit_any;
                    found_next    = 1'b0;
                    state_next    = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_page_next  = res_page_reg;
                    m_tab_next   = res_tab_reg;
                    m_drop_next  = res_drop_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_granted_page    = m_page_reg;
    assign m_from_table      = m_tab_reg;
    assign m_release_dropped = m_drop_reg;

    // checks
    a_idle_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (cnt_reg == '0 && !found_reg))
        else $error("pass counter not cleared in idle");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_from_table && m_release_dropped))
        else $error("result flags both set");

    a_cfg_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wen && state_reg == ST_IDLE && !accept) |=> (top_reg == $past(cfg_wdata)))
        else $error("config write did not load top");

endmodule

[bench/extent_table_space_allocator_unit_tb.sv]
module extent_table_space_allocator_unit_tb;
    import easp_pkg::*;

    localparam bit KIND_ALLOC   = 1'b0;
    localparam bit KIND_RELEASE = 1'b1;
    localparam logic [PAGE_W-1:0] PAGE_TOP = {PAGE_W{1'b1}};
    localparam logic [LEN_W-1:0]  LEN_TOP  = {LEN_W{1'b1}};

    // expected grant for one word
    typedef struct {
        logic [PAGE_W-1:0] page;
        logic              tbl;
        logic              drop;
    } grant_t;

    // free extent table, top pointer and the grants still owed by the block
    class alloc_scoreboard;
        logic [PAGE_W-1:0] ext_start [EXTENT_SLOTS];
        logic [LEN_W-1:0]  ext_len   [EXTENT_SLOTS];
        logic [PAGE_W-1:0] top;
        grant_t            owed_q [$];
        int                errors;

        function new();
            foreach (ext_start[i]) begin
                ext_start[i] = '0;
                ext_len[i]   = '0;
            end
            top    = '0;
            errors = 0;
        endfunction

        function void load_base(logic [PAGE_W-1:0] v);
            top = v;
        endfunction

        function logic [PAGE_W-1:0] ext_end(int i);
            return ext_start[i] + PAGE_W'(ext_len[i]);
        endfunction

        // first fit from the table, else bump the top
        function grant_t take_pages(logic [LEN_W-1:0] n);
            grant_t g;
            g.drop = 1'b0;
            for (int i = 0; i < EXTENT_SLOTS; i++) begin
                if (ext_len[i] >= n) begin
                    g.page       = ext_start[i];
                    g.tbl        = 1'b1;
                    ext_start[i] = ext_start[i] + PAGE_W'(n);
                    ext_len[i]   = ext_len[i] - n;
                    if (ext_len[i] == 0)
                        ext_start[i] = '0;
                    return g;
                end
            end
            g.page = top;
            g.tbl  = 1'b0;
            top    = top + PAGE_W'(n);
            return g;
        endfunction

        // returns 1 when the range could be neither merged nor stored
        function logic give_back(logic [PAGE_W-1:0] s, logic [LEN_W-1:0] n);
            logic [PAGE_W-1:0] e;
            logic [LEN_W:0]    grown;
            bit                merged;
            if (s == 0 || n == 0)
                return 1'b0;
            e = s + PAGE_W'(n);
            // release at the top, then swallow extents ending at the new top
            if (e == top) begin
                top = s;
                do begin
                    merged = 0;
                    for (int i = 0; i < EXTENT_SLOTS; i++) begin
                        if (ext_len[i] != 0 && ext_end(i) == top) begin
                            top          = ext_start[i];
                            ext_start[i] = '0;
                            ext_len[i]   = '0;
                            merged       = 1;
                            break;
                        end
                    end
                end while (merged);
                return 1'b0;
            end
            // append or prepend to the first neighbor that has room
            for (int i = 0; i < EXTENT_SLOTS; i++) begin
                grown = {1'b0, ext_len[i]} + {1'b0, n};
                if (ext_len[i] == 0 || grown[LEN_W])
                    continue;
                if (ext_end(i) == s) begin
                    ext_len[i] = grown[LEN_W-1:0];
                    return 1'b0;
                end
                if (e == ext_start[i]) begin
                    ext_start[i] = s;
                    ext_len[i]   = grown[LEN_W-1:0];
                    return 1'b0;
                end
            end
            // first empty slot
            for (int i = 0; i < EXTENT_SLOTS; i++) begin
                if (ext_len[i] == 0) begin
                    ext_start[i] = s;
                    ext_len[i]   = n;
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function logic [PAGE_W-1:0] note_request(logic kind, logic [PAGE_W-1:0] s,
                                                 logic [LEN_W-1:0] n);
            grant_t g;
            if (kind == KIND_ALLOC) begin
                g = take_pages(n);
            end else begin
                g.page = '0;
                g.tbl  = 1'b0;
                g.drop = give_back(s, n);
            end
            owed_q.push_back(g);
            return g.page;
        endfunction

        function void check_result(logic [PAGE_W-1:0] page, logic tbl, logic drop);
            grant_t g;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word page=%h tbl=%b drop=%b",
                             page, tbl, drop);
                return;
            end
            g = owed_q.pop_front();
            if (page !== g.page || tbl !== g.tbl || drop !== g.drop) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp page=%h tbl=%b drop=%b got page=%h tbl=%b drop=%b",
                             g.page, g.tbl, g.drop, page, tbl, drop);
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wen = 1'b0;
    logic [PAGE_W-1:0] cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_kind = 1'b0;
    logic [PAGE_W-1:0] s_start_page = '0;
    logic [LEN_W-1:0]  s_page_count = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [PAGE_W-1:0] m_granted_page;
    logic              m_from_table;
    logic              m_release_dropped;

    alloc_scoreboard sb = new();

    extent_table_space_allocator_unit i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wen           (cfg_wen),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_start_page      (s_start_page),
        .s_page_count      (s_page_count),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_granted_page    (m_granted_page),
        .m_from_table      (m_from_table),
        .m_release_dropped (m_release_dropped)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // result side: check accepted words
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_granted_page, m_from_table, m_release_dropped);
    end

    // receiver stall pattern, with a stall mode picked at random from time to time
    int unsigned stall_mode = 0;
    int unsigned stall_cnt  = 0;
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_cnt % 64) > 50;
        endcase
    end

    // generous fixed limit
    initial begin
        #320000000;
        $display("extent_table_space_allocator_unit_tb failed");
        $finish;
    end

    int burst_left = 0;

    // drive one word, wait for acceptance, then maybe leave a gap
    task automatic issue(input logic kind, input logic [PAGE_W-1:0] s,
                         input logic [LEN_W-1:0] n, output logic [PAGE_W-1:0] page);
        int gap;
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_start_page <= s;
        s_page_count <= n;
        do @(posedge aclk); while (!s_ready);
        page = sb.note_request(kind, s, n);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // sender holds off until every owed word is back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.owed_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_base(input logic [PAGE_W-1:0] v);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        sb.load_base(v);
        @(posedge aclk);
    endtask

    initial begin
        logic [PAGE_W-1:0] a, b, c, p;
        logic [PAGE_W-1:0] held_start [$];
        logic [LEN_W-1:0]  held_len   [$];
        logic [LEN_W-1:0]  n, half;
        int                idx, pick;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero count on an empty table, ignored releases
        issue(KIND_ALLOC, '0, '0, p);
        issue(KIND_RELEASE, '0, 20'd5, p);
        issue(KIND_RELEASE, 36'd7, '0, p);
        write_base(36'h1000);
        // max count, then overflowing append and absorb chain at the top
        issue(KIND_ALLOC, '0, LEN_TOP, a);
        issue(KIND_ALLOC, '0, 20'd4, b);
        issue(KIND_ALLOC, '0, 20'd4, c);
        issue(KIND_RELEASE, a, LEN_TOP, p);
        issue(KIND_RELEASE, b, 20'd4, p);
        issue(KIND_RELEASE, c, 20'd4, p);
        // zero count hitting a live slot 0, then emptying it
        issue(KIND_ALLOC, '0, 20'd8, a);
        issue(KIND_ALLOC, '0, 20'd8, b);
        issue(KIND_RELEASE, a, 20'd8, p);
        issue(KIND_ALLOC, '0, '0, p);
        issue(KIND_ALLOC, '0, 20'd8, p);
        issue(KIND_RELEASE, b, 20'd8, p);
        // wrap past the end of the page space, prepend merge
        write_base(PAGE_TOP - 36'd7);
        issue(KIND_ALLOC, '0, 20'd16, a);
        issue(KIND_ALLOC, '0, 20'd4, b);
        issue(KIND_ALLOC, '0, 20'd4, c);
        issue(KIND_RELEASE, b, 20'd4, p);
        issue(KIND_RELEASE, a, 20'd16, p);
        issue(KIND_RELEASE, c, 20'd4, p);
        issue(KIND_RELEASE, PAGE_TOP, LEN_TOP, p);

        // random: mostly alloc and release of live ranges, some noise
        write_base(36'h40);
        for (int k = 0; k < 640; k++) begin
            if (k == 320)
                drain();
            if (k == 400)
                write_base(36'h8000_0000 + 36'($urandom_range(0, 255)));
            pick = $urandom_range(0, 99);
            if (held_start.size() > 150 && pick < 45)
                pick = 60;
            if (held_start.size() == 0 && pick >= 45 && pick < 90)
                pick = 0;
            if (pick < 45) begin
                case ($urandom_range(0, 19))
                    0:       n = '0;
                    1:       n = 20'($urandom_range(1, 4096));
                    2:       n = 20'($urandom);
                    default: n = 20'($urandom_range(1, 16));
                endcase
                issue(KIND_ALLOC, '0, n, a);
                if (n != 0) begin
                    held_start.push_back(a);
                    held_len.push_back(n);
                end
            end else if (pick < 80 || (pick < 90 && held_len[0] < 2)) begin
                idx = $urandom_range(0, held_start.size() - 1);
                issue(KIND_RELEASE, held_start[idx], held_len[idx], p);
                held_start.delete(idx);
                held_len.delete(idx);
            end else if (pick < 90) begin
                // split release, back half first
                half = held_len[0] / 2;
                a    = held_start[0];
                n    = held_len[0];
                held_start.delete(0);
                held_len.delete(0);
                issue(KIND_RELEASE, a + PAGE_W'(half), n - half, p);
                issue(KIND_RELEASE, a, half, p);
            end else begin
                a = {4'($urandom), 32'($urandom)};
                if ($urandom_range(0, 5) == 0)
                    a = '0;
                n = ($urandom_range(0, 5) == 0) ? '0 : 20'($urandom);
                issue(KIND_RELEASE, a, n, p);
            end
        end

        // fill the table with scattered ranges until releases are dropped
        write_base(36'h100);
        for (int k = 0; k < 270; k++)
            issue(KIND_RELEASE, 36'h8_0000_0000 + 36'(k) * 36'd4, 20'd2, p);
        for (int k = 0; k < 30; k++)
            issue(KIND_ALLOC, '0, 20'($urandom_range(1, 3)), p);
        write_base('0);
        for (int k = 0; k < 10; k++)
            issue(KIND_ALLOC, '0, 20'($urandom_range(0, 2)), p);

        drain();
        repeat (600) @(posedge aclk);
        if (sb.errors == 0 && sb.owed_q.size() == 0) begin
            $display("extent_table_space_allocator_unit_tb passed");
        end else begin
            $display("extent_table_space_allocator_unit_tb failed");
        end
        $finish;
    end
endmodule
